FILE: src/pa_pkg.sv
package pa_pkg;

  localparam int MAX_PARTS = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int ADDR_W = 16;
  localparam logic [ADDR_W-1:0] RESERVED_SIZE = 16'd30;
  localparam logic [15:0] HANDLE_MAX = 16'hFFFF;
  localparam logic [15:0] TOTAL_RESET = 16'd1024;
  localparam logic [1:0] POLICY_RESET = 2'd1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BADHANDLE = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [0:0] REG_TOTAL = 1'd0;
  localparam logic [0:0] REG_POLICY = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic used;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic action;
    logic [15:0] alloc_size;
    logic [15:0] free_handle;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] granted_handle;
    logic [15:0] start_addr;
  } rsp_t;

  typedef struct packed {
    logic [0:0] index;
    logic [15:0] data;
  } cfg_t;

endpackage

FILE: src/pa_if.sv
interface pa_req_if;
  logic valid;
  logic ready;
  pa_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pa_rsp_if;
  logic valid;
  logic ready;
  pa_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pa_cfg_if;
  logic valid;
  logic ready;
  pa_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/pa_table.sv
module pa_table (
  input  logic clk,
  input  logic we,
  input  logic [pa_pkg::IDX_W-1:0] waddr,
  input  pa_pkg::entry_t wdata,
  input  logic [pa_pkg::IDX_W-1:0] raddr,
  output pa_pkg::entry_t rdata
);

  pa_pkg::entry_t mem [pa_pkg::MAX_PARTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pa_ctrl.sv
module pa_ctrl (
  input  logic clk,
  input  logic rst,
  pa_req_if.sink req,
  pa_rsp_if.source rsp,
  pa_cfg_if.sink cfg
);

  localparam logic [3:0] S_INIT0 = 4'd0;
  localparam logic [3:0] S_INIT1 = 4'd1;
  localparam logic [3:0] S_IDLE = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SHUP = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_FREE_NB = 4'd7;
  localparam logic [3:0] S_FREE_PV = 4'd8;
  localparam logic [3:0] S_SHDN = 4'd9;
  localparam logic [3:0] S_OUT = 4'd10;

  logic [3:0] state;
  logic [15:0] total_size;
  logic [1:0] fit_policy;
  logic [pa_pkg::CNT_W-1:0] part_count;
  logic [15:0] next_id;
  pa_pkg::req_t cur;
  pa_pkg::rsp_t res;

  logic [pa_pkg::CNT_W-1:0] ridx;
  logic rpend;
  logic [pa_pkg::CNT_W-1:0] rtag;
  pa_pkg::entry_t rdata;

  logic found;
  logic [pa_pkg::IDX_W-1:0] pick;
  pa_pkg::entry_t pent;
  logic prev_ok;
  logic [pa_pkg::CNT_W-1:0] ptr;
  logic [pa_pkg::CNT_W-1:0] lim;
  pa_pkg::entry_t carry;
  logic merged_nb;
  logic shpend;

  logic we;
  logic [pa_pkg::IDX_W-1:0] waddr;
  pa_pkg::entry_t wdata;
  logic [pa_pkg::IDX_W-1:0] raddr;

  logic rsp_full;

  pa_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign cfg.ready = (state == S_IDLE) && !rsp_full;
  assign req.ready = (state == S_IDLE) && !rsp_full && !cfg.valid;
  assign rsp.valid = rsp_full;
  assign rsp.data = res;

  logic cand;
  logic better;
  always_comb begin
    cand = !rdata.used && rdata.len >= cur.alloc_size && rdata.len != '0
           && cur.alloc_size != '0;
    better = 1'b0;
    if (cand) begin
      case (fit_policy)
        pa_pkg::POL_FIRST: better = !found;
        pa_pkg::POL_WORST: better = !found || rdata.len >= pent.len;
        default:           better = !found || rdata.len < pent.len;
      endcase
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = ridx[pa_pkg::IDX_W-1:0];
    case (state)
      S_INIT0: begin
        we = 1'b1;
        waddr = '0;
        wdata = '{start: '0, len: pa_pkg::RESERVED_SIZE, used: 1'b1, id: 16'd0};
      end
      S_INIT1: begin
        we = total_size > 16'(pa_pkg::RESERVED_SIZE);
        waddr = 4'd1;
        wdata = '{start: pa_pkg::RESERVED_SIZE,
                  len: total_size - 16'(pa_pkg::RESERVED_SIZE), used: 1'b0, id: 16'd1};
      end
      S_SHUP: begin
        if (shpend && ptr > 5'(pick)) begin
          we = 1'b1;
          waddr = ptr[pa_pkg::IDX_W-1:0];
          wdata = rdata;
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = pick;
        wdata = '{start: pent.start, len: cur.alloc_size, used: 1'b1, id: next_id + 16'd1};
      end
      S_FREE_NB: begin
        we = 1'b1;
        waddr = pick;
        wdata = carry;
      end
      S_FREE_PV: begin
        we = 1'b1;
        waddr = pick;
        wdata = carry;
      end
      S_SHDN: begin
        we = 1'b1;
        if (shpend) begin
          waddr = 4'(ptr - 5'd1);
          wdata = rdata;
        end else begin
          waddr = pick;
          wdata = carry;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
      total_size <= pa_pkg::TOTAL_RESET;
      fit_policy <= pa_pkg::POLICY_RESET;
      part_count <= 5'd2;
      next_id <= 16'd1;
      rsp_full <= 1'b0;
      rpend <= 1'b0;
      ridx <= '0;
    end else begin
      if (rsp_full && rsp.ready) begin
        rsp_full <= 1'b0;
      end
      case (state)
        S_INIT0: state <= S_INIT1;
        S_INIT1: begin
          part_count <= (total_size > 16'(pa_pkg::RESERVED_SIZE)) ? 5'd2 : 5'd1;
          next_id <= 16'd1;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg.valid && cfg.ready) begin
            if (cfg.data.index == pa_pkg::REG_TOTAL) begin
              total_size <= cfg.data.data;
              state <= S_INIT0;
            end else begin
              fit_policy <= cfg.data.data[1:0];
            end
          end else if (req.valid && req.ready) begin
            cur <= req.data;
            res <= '0;
            found <= 1'b0;
            ridx <= 5'd1;
            rpend <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rpend) begin
            if (cur.action == pa_pkg::ACT_REQUEST) begin
              if (better) begin
                found <= 1'b1;
                pick <= rtag[pa_pkg::IDX_W-1:0];
                pent <= rdata;
              end
            end else if (!found && rdata.used && rdata.id == cur.free_handle) begin
              found <= 1'b1;
              pick <= rtag[pa_pkg::IDX_W-1:0];
              pent <= rdata;
            end
          end
          if (ridx < part_count) begin
            rtag <= ridx;
            rpend <= 1'b1;
            ridx <= ridx + 5'd1;
          end else begin
            rpend <= 1'b0;
            if (!rpend) state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cur.action == pa_pkg::ACT_REQUEST) begin
            if (!found) begin
              res.status <= pa_pkg::ST_NOFIT;
              state <= S_OUT;
            end else if (next_id >= pa_pkg::HANDLE_MAX) begin
              res.status <= pa_pkg::ST_EXHAUSTED;
              state <= S_OUT;
            end else if (pent.len == cur.alloc_size) begin
              carry <= '{start: pent.start, len: pent.len, used: 1'b1,
                         id: next_id + 16'd1};
              next_id <= next_id + 16'd1;
              res <= '{status: pa_pkg::ST_OK, granted_handle: next_id + 16'd1,
                       start_addr: pent.start};
              state <= S_FREE_NB;
              merged_nb <= 1'b1;
            end else if (part_count >= 5'(pa_pkg::MAX_PARTS)) begin
              res.status <= pa_pkg::ST_EXHAUSTED;
              state <= S_OUT;
            end else begin
              res <= '{status: pa_pkg::ST_OK, granted_handle: next_id + 16'd1,
                       start_addr: pent.start};
              ptr <= part_count;
              ridx <= part_count - 5'd1;
              shpend <= 1'b0;
              state <= S_SHUP;
            end
          end else begin
            if (!found || cur.free_handle == 16'd0) begin
              res.status <= pa_pkg::ST_BADHANDLE;
              state <= S_OUT;
            end else begin
              res <= '{status: pa_pkg::ST_OK, granted_handle: 16'd0, start_addr: pent.start};
              carry <= '{start: pent.start, len: pent.len, used: 1'b0, id: pent.id};
              merged_nb <= 1'b0;
              ridx <= 5'(pick) + 5'd1;
              rpend <= 1'b0;
              state <= S_FREE_NB;
            end
          end
        end
        S_SHUP: begin
          if (shpend) ptr <= ptr - 5'd1;
          if (shpend && ptr == 5'(pick) + 5'd1) begin
            state <= S_SPLIT;
          end else begin
            shpend <= 1'b1;
            ridx <= ridx - 5'd1;
          end
        end
        S_SPLIT: begin
          carry <= '{start: pent.start + cur.alloc_size, len: pent.len - cur.alloc_size,
                     used: 1'b0, id: pent.id};
          pick <= pick + 4'd1;
          part_count <= part_count + 5'd1;
          next_id <= next_id + 16'd1;
          merged_nb <= 1'b1;
          state <= S_FREE_NB;
        end
        S_FREE_NB: begin
          if (merged_nb) begin
            state <= S_OUT;
          end else if (!rpend) begin
            rpend <= 1'b1;
          end else begin
            rpend <= 1'b0;
            merged_nb <= 1'b1;
            if (5'(pick) + 5'd1 < part_count && !rdata.used) begin
              carry.len <= carry.len + rdata.len;
              lim <= 5'(pick) + 5'd1;
              prev_ok <= 1'b1;
            end else begin
              prev_ok <= 1'b0;
            end
            ridx <= 5'(pick) - 5'd1;
            state <= S_FREE_PV;
          end
        end
        S_FREE_PV: begin
          if (!rpend) begin
            rpend <= 1'b1;
          end else begin
            rpend <= 1'b0;
            if (!rdata.used) begin
              carry <= '{start: rdata.start, len: rdata.len + carry.len,
                         used: 1'b0, id: rdata.id};
              pick <= pick - 4'd1;
              if (prev_ok) begin
                ptr <= lim;
                part_count <= part_count - 5'd2;
                lim <= part_count - 5'd1;
                ridx <= lim + 5'd1;
              end else begin
                ptr <= 5'(pick) + 5'd1;
                part_count <= part_count - 5'd1;
                lim <= part_count;
                ridx <= 5'(pick) + 5'd1;
              end
              shpend <= 1'b0;
              state <= S_SHDN;
            end else if (prev_ok) begin
              ptr <= lim + 5'd1;
              lim <= part_count;
              part_count <= part_count - 5'd1;
              ridx <= lim + 5'd1;
              shpend <= 1'b0;
              state <= S_SHDN;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SHDN: begin
          if (!shpend && ptr >= lim) begin
            state <= S_OUT;
          end else if (shpend) begin
            ptr <= ptr + 5'd1;
            ridx <= ridx + 5'd1;
            shpend <= (ptr + 5'd1 < lim);
            if (ptr + 5'd1 >= lim) state <= S_OUT;
          end else begin
            shpend <= 1'b1;
            ridx <= ridx + 5'd1;
          end
        end
        S_OUT: begin
          rsp_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/partition_allocator_unit.sv
// partition allocator: an address-ordered table of variable partitions
// channels: req (action, alloc_size, free_handle), rsp (status,
//   granted_handle, start_addr), cfg (index 0 total_size, 1 fit_policy)
// every request gives exactly one response on rsp
// sequence: a table scan of one memory read per entry, a decide step and
//   an output step, then for a split a shift of one entry per cycle, and
//   for a free two neighbor reads plus, when a neighbor merges, a shift
//   down of the entries above; each read uses the single read port of
//   the table memory
// one request is in work at a time; req.ready is low while it runs
// a finished response waits in the output register while rsp.ready is
//   low, and no new request or config write is taken until it leaves
// reset (rst, synchronous): total_size 1024, best fit; the table is rebuilt
//   in S_INIT0 and S_INIT1 with the 30-unit reserved partition and, if
//   total_size > 30, one free partition; a total_size write does the same
module partition_allocator_unit (
  input logic clk,
  input logic rst,
  pa_req_if.sink req,
  pa_rsp_if.source rsp,
  pa_cfg_if.sink cfg
);

  pa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );

endmodule
